// ===== sv/emgdm_pkg.sv =====
// Shared types, constants and codes for the muscle-signal drive mixer.
// Used by every module of the block; depends on nothing.
package emgdm_pkg;

    // Field widths
    localparam int SAMPLE_BITS   = 12;
    localparam int FRAC_BITS     = 16;
    localparam int DIST_BITS     = 16;
    localparam int TICK_BITS     = 8;
    localparam int DRIVE_BITS    = 9;
    localparam int CMD_BITS      = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Drive scaling: full scale is 2^DRIVE_SHIFT - 1
    localparam int DRIVE_SHIFT = 8;
    localparam int DRIVE_MAX   = (1 << DRIVE_SHIFT) - 1;

    // Register reset values
    localparam logic [SAMPLE_BITS-1:0] CH_LOW_RST  = '0;
    localparam logic [SAMPLE_BITS-1:0] CH_HIGH_RST = SAMPLE_BITS'(4095);
    localparam logic [DIST_BITS-1:0]   SAFETY_RST  = DIST_BITS'(100);
    localparam logic [TICK_BITS-1:0]   TIMEOUT_RST = TICK_BITS'(4);
    localparam logic [TICK_BITS-1:0]   TICK_SAT    = '1;

    // Fixed-point datapath widths
    localparam int QUO_BITS   = FRAC_BITS + 2;
    localparam int UNIT_BITS  = FRAC_BITS + 2;
    localparam int SUM_BITS   = FRAC_BITS + 3;
    localparam int PROD_BITS  = SUM_BITS + DRIVE_SHIFT;
    localparam int SCALE_BITS = PROD_BITS - FRAC_BITS;
    localparam int STEP_BITS  = $clog2(QUO_BITS);

    localparam logic [UNIT_BITS-1:0] UNIT_ONE       = UNIT_BITS'(1) << FRAC_BITS;
    localparam logic [UNIT_BITS-1:0] UNIT_MINUS_ONE = ~UNIT_ONE + UNIT_BITS'(1);
    localparam logic signed [PROD_BITS-1:0]  ROUND_BIAS = PROD_BITS'((1 << FRAC_BITS) - 1);
    localparam logic signed [SCALE_BITS-1:0] SCALE_MAX  = SCALE_BITS'(DRIVE_MAX);
    localparam logic signed [SCALE_BITS-1:0] SCALE_MIN  = SCALE_BITS'(-DRIVE_MAX);

    // Job queue between front and back
    localparam int JOBQ_DEPTH    = 2;
    localparam int JOBQ_PTR_BITS = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_BITS = $clog2(JOBQ_DEPTH + 1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TICK   = CMD_BITS'(0),
        CMD_SAMPLE = CMD_BITS'(1),
        CMD_RANGE  = CMD_BITS'(2)
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CH1_LOW  = CFG_IDX_BITS'(0),
        CFG_CH1_HIGH = CFG_IDX_BITS'(1),
        CFG_CH2_LOW  = CFG_IDX_BITS'(2),
        CFG_CH2_HIGH = CFG_IDX_BITS'(3),
        CFG_SAFETY   = CFG_IDX_BITS'(4),
        CFG_TIMEOUT  = CFG_IDX_BITS'(5)
    } cfg_idx_t;

    // How one channel turns into a unit value
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_NEG,
        MODE_POS,
        MODE_DIV
    } ch_mode_t;

    typedef struct packed {
        ch_mode_t               mode;
        logic [SAMPLE_BITS-1:0] offset;
        logic [SAMPLE_BITS-1:0] span;
    } chan_job_t;

    typedef struct packed {
        chan_job_t ch1;
        chan_job_t ch2;
        logic      active;
        logic      near;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_DIV,
        BK_MIX
    } back_state_t;

endpackage

// ===== sv/emgdm_front.sv =====
// Front end: takes commands, holds configuration and latched sensor state,
// and turns each control tick into a job. Depends on emgdm_pkg.
module emgdm_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [emgdm_pkg::CMD_BITS-1:0]       command,
    input  logic [emgdm_pkg::SAMPLE_BITS-1:0]    emg_ch1,
    input  logic [emgdm_pkg::SAMPLE_BITS-1:0]    emg_ch2,
    input  logic [emgdm_pkg::DIST_BITS-1:0]      range_mm,
    input  logic                                 cfg_valid,
    input  logic [emgdm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [emgdm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                 jobq_full,
    output logic                                 job_push,
    output emgdm_pkg::job_t                      job
);
    import emgdm_pkg::*;

    logic [SAMPLE_BITS-1:0] ch1_low_reg,  ch1_low_next;
    logic [SAMPLE_BITS-1:0] ch1_high_reg, ch1_high_next;
    logic [SAMPLE_BITS-1:0] ch2_low_reg,  ch2_low_next;
    logic [SAMPLE_BITS-1:0] ch2_high_reg, ch2_high_next;
    logic [DIST_BITS-1:0]   safety_reg,   safety_next;
    logic [TICK_BITS-1:0]   timeout_reg,  timeout_next;
    logic [SAMPLE_BITS-1:0] ch1_level_reg, ch1_level_next;
    logic [SAMPLE_BITS-1:0] ch2_level_reg, ch2_level_next;
    logic [DIST_BITS-1:0]   obstacle_reg,  obstacle_next;
    logic [TICK_BITS-1:0]   ticks_reg,     ticks_next;
    logic                   accept;

    // Clamp to the window and pick how the back end derives the unit value
    function automatic chan_job_t classify(
        input logic [SAMPLE_BITS-1:0] x,
        input logic [SAMPLE_BITS-1:0] lo,
        input logic [SAMPLE_BITS-1:0] hi
    );
        chan_job_t              c;
        logic [SAMPLE_BITS-1:0] clamped;
        c.mode   = MODE_ZERO;
        c.offset = '0;
        c.span   = '0;
        clamped  = x;
        if (x < lo)
        begin
            clamped = lo;
        end
        else if (x > hi)
        begin
            clamped = hi;
        end
        if (lo == hi)
        begin
            c.mode = MODE_ZERO;
        end
        else if (lo > hi)
        begin
            // inverted window: below the lower edge is -1, anything else +1
            c.mode = (x < lo) ? MODE_NEG : MODE_POS;
        end
        else
        begin
            c.mode   = MODE_DIV;
            c.offset = clamped - lo;
            c.span   = hi - lo;
        end
        return c;
    endfunction

    assign accept = push && !jobq_full;

    always_comb
    begin
        ch1_low_next   = ch1_low_reg;
        ch1_high_next  = ch1_high_reg;
        ch2_low_next   = ch2_low_reg;
        ch2_high_next  = ch2_high_reg;
        safety_next    = safety_reg;
        timeout_next   = timeout_reg;
        ch1_level_next = ch1_level_reg;
        ch2_level_next = ch2_level_reg;
        obstacle_next  = obstacle_reg;
        ticks_next     = ticks_reg;
        job_push       = 1'b0;

        job.ch1    = classify(ch1_level_reg, ch1_low_reg, ch1_high_reg);
        job.ch2    = classify(ch2_level_reg, ch2_low_reg, ch2_high_reg);
        job.active = ticks_reg < timeout_reg;
        job.near   = obstacle_reg < safety_reg;

        if (accept)
        begin
            unique case (cmd_t'(command))
                CMD_TICK:
                begin
                    job_push = 1'b1;
                    if (ticks_reg != TICK_SAT)
                    begin
                        ticks_next = ticks_reg + TICK_BITS'(1);
                    end
                end
                CMD_SAMPLE:
                begin
                    ch1_level_next = emg_ch1;
                    ch2_level_next = emg_ch2;
                    ticks_next     = '0;
                end
                CMD_RANGE:
                begin
                    obstacle_next = range_mm;
                end
                default:
                begin
                    // unused code: drop
                end
            endcase
        end

        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CH1_LOW:  ch1_low_next  = cfg_data[SAMPLE_BITS-1:0];
                CFG_CH1_HIGH: ch1_high_next = cfg_data[SAMPLE_BITS-1:0];
                CFG_CH2_LOW:  ch2_low_next  = cfg_data[SAMPLE_BITS-1:0];
                CFG_CH2_HIGH: ch2_high_next = cfg_data[SAMPLE_BITS-1:0];
                CFG_SAFETY:   safety_next   = cfg_data[DIST_BITS-1:0];
                CFG_TIMEOUT:  timeout_next  = cfg_data[TICK_BITS-1:0];
                default:
                begin
                    // no register here: drop
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch1_low_reg   <= CH_LOW_RST;
            ch1_high_reg  <= CH_HIGH_RST;
            ch2_low_reg   <= CH_LOW_RST;
            ch2_high_reg  <= CH_HIGH_RST;
            safety_reg    <= SAFETY_RST;
            timeout_reg   <= TIMEOUT_RST;
            ch1_level_reg <= '0;
            ch2_level_reg <= '0;
            obstacle_reg  <= '0;
            ticks_reg     <= TICK_SAT;
        end
        else
        begin
            ch1_low_reg   <= ch1_low_next;
            ch1_high_reg  <= ch1_high_next;
            ch2_low_reg   <= ch2_low_next;
            ch2_high_reg  <= ch2_high_next;
            safety_reg    <= safety_next;
            timeout_reg   <= timeout_next;
            ch1_level_reg <= ch1_level_next;
            ch2_level_reg <= ch2_level_next;
            obstacle_reg  <= obstacle_next;
            ticks_reg     <= ticks_next;
        end
    end

endmodule

// ===== sv/emgdm_job_queue.sv =====
// Short job queue that decouples the front end from the divide/mix back end.
// Depends on emgdm_pkg (job_t, JOBQ_DEPTH).
module emgdm_job_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  emgdm_pkg::job_t wr_data,
    input  logic            rd_en,
    output emgdm_pkg::job_t rd_data,
    output logic            full,
    output logic            empty
);
    import emgdm_pkg::*;

    job_t                     mem_reg [JOBQ_DEPTH];
    logic [JOBQ_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOBQ_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOBQ_CNT_BITS-1:0] count_reg,  count_next;
    logic                     do_wr;
    logic                     do_rd;

    assign full    = count_reg == JOBQ_CNT_BITS'(JOBQ_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == JOBQ_PTR_BITS'(JOBQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + JOBQ_PTR_BITS'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == JOBQ_PTR_BITS'(JOBQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + JOBQ_PTR_BITS'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + JOBQ_CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - JOBQ_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/emgdm_back.sv =====
// Back end: serial restoring divider shared by both channels, drive mixer,
// obstacle and timeout gating, and the result register. Depends on emgdm_pkg.
module emgdm_back (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     jobq_empty,
    input  emgdm_pkg::job_t                          job,
    output logic                                     jobq_pop,
    input  logic                                     pop,
    output logic                                     empty,
    output logic signed [emgdm_pkg::DRIVE_BITS-1:0]  left_drive,
    output logic signed [emgdm_pkg::DRIVE_BITS-1:0]  right_drive
);
    import emgdm_pkg::*;

    back_state_t               state_reg, state_next;
    job_t                      job_reg, job_next;
    logic                      ch_sel_reg, ch_sel_next;
    logic [STEP_BITS-1:0]      step_reg, step_next;
    logic [SAMPLE_BITS-1:0]    rem_reg, rem_next;
    logic [QUO_BITS-1:0]       quo_reg, quo_next;
    logic signed [UNIT_BITS-1:0] t_reg, t_next;
    logic signed [UNIT_BITS-1:0] r_reg, r_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [DRIVE_BITS-1:0] left_reg, left_next;
    logic signed [DRIVE_BITS-1:0] right_reg, right_next;

    chan_job_t                 cur;
    logic [SAMPLE_BITS:0]      trial;
    logic [SAMPLE_BITS:0]      diff;
    logic                      ge;
    logic [QUO_BITS-1:0]       quo_step;
    logic [UNIT_BITS-1:0]      unit_val;
    logic                      unit_we;
    logic signed [SUM_BITS-1:0]   sum_l, sum_r;
    logic signed [DRIVE_BITS-1:0] left_mix, right_mix;
    logic                      blocked;

    // d * 255 / 2^FRAC_BITS, truncated toward zero, saturated to full scale
    function automatic logic signed [DRIVE_BITS-1:0] to_drive(
        input logic signed [SUM_BITS-1:0] d
    );
        logic signed [PROD_BITS-1:0]  p;
        logic signed [PROD_BITS-1:0]  adj;
        logic signed [SCALE_BITS-1:0] s;
        logic signed [SCALE_BITS-1:0] sat;
        p   = (PROD_BITS'(d) <<< DRIVE_SHIFT) - PROD_BITS'(d);
        adj = p[PROD_BITS-1] ? p + ROUND_BIAS : p;
        s   = SCALE_BITS'(adj >>> FRAC_BITS);
        sat = s;
        if (s > SCALE_MAX)
        begin
            sat = SCALE_MAX;
        end
        else if (s < SCALE_MIN)
        begin
            sat = SCALE_MIN;
        end
        return DRIVE_BITS'(sat);
    endfunction

    // one quotient bit per cycle; the first step compares without a shift
    assign cur      = ch_sel_reg ? job_reg.ch2 : job_reg.ch1;
    assign trial    = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign ge       = trial >= {1'b0, cur.span};
    assign diff     = ge ? trial - {1'b0, cur.span} : trial;
    assign quo_step = {quo_reg[QUO_BITS-2:0], ge};

    assign sum_l     = SUM_BITS'(t_reg) - SUM_BITS'(r_reg);
    assign sum_r     = SUM_BITS'(t_reg) + SUM_BITS'(r_reg);
    assign left_mix  = to_drive(sum_l);
    assign right_mix = to_drive(sum_r);
    assign blocked   = job_reg.near && (left_mix > 0 || right_mix > 0);

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        ch_sel_next    = ch_sel_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        t_next         = t_reg;
        r_next         = r_reg;
        out_valid_next = out_valid_reg && !pop;
        left_next      = left_reg;
        right_next     = right_reg;
        jobq_pop       = 1'b0;
        unit_val       = '0;
        unit_we        = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!jobq_empty)
                begin
                    jobq_pop    = 1'b1;
                    job_next    = job;
                    ch_sel_next = 1'b0;
                    state_next  = job.active ? BK_LOAD : BK_MIX;
                end
            end
            BK_LOAD:
            begin
                unique case (cur.mode)
                    MODE_DIV:
                    begin
                        rem_next   = cur.offset;
                        quo_next   = '0;
                        step_next  = '0;
                        state_next = BK_DIV;
                    end
                    MODE_NEG:
                    begin
                        unit_val = UNIT_MINUS_ONE;
                        unit_we  = 1'b1;
                    end
                    MODE_POS:
                    begin
                        unit_val = UNIT_ONE;
                        unit_we  = 1'b1;
                    end
                    default:
                    begin
                        unit_val = '0;
                        unit_we  = 1'b1;
                    end
                endcase
            end
            BK_DIV:
            begin
                rem_next  = diff[SAMPLE_BITS-1:0];
                quo_next  = quo_step;
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_BITS'(QUO_BITS - 1))
                begin
                    unit_val = quo_step - UNIT_ONE;
                    unit_we  = 1'b1;
                end
            end
            BK_MIX:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    if (!job_reg.active || blocked)
                    begin
                        left_next  = '0;
                        right_next = '0;
                    end
                    else
                    begin
                        left_next  = left_mix;
                        right_next = right_mix;
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // store the channel's unit value and move to the next channel or mix
        if (unit_we)
        begin
            if (!ch_sel_reg)
            begin
                t_next      = unit_val;
                ch_sel_next = 1'b1;
                state_next  = BK_LOAD;
            end
            else
            begin
                r_next     = unit_val;
                state_next = BK_MIX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            ch_sel_reg    <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_sel_reg    <= ch_sel_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        t_reg     <= t_next;
        r_reg     <= r_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    assign empty       = !out_valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;

endmodule

// ===== sv/emg_differential_drive_mixer_core.sv =====
// Top level of the muscle-signal differential drive mixer.
// Depends on emgdm_pkg, emgdm_front, emgdm_job_queue and emgdm_back.
//
//  Channel   Handshake              Beat carries
//  --------  ---------------------  -------------------------------------------
//  input     push / full            command, emg_ch1, emg_ch2, range_mm
//  result    empty / pop            left_drive, right_drive (one per tick)
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Sample and range commands update the latched state in the cycle they are
// taken. A control tick's job moves from the queue into the back end, then
// each channel takes a load step and a FRAC_BITS+2 bit divide on a restoring
// divider that yields one quotient bit per cycle (both channels share the
// divider), and a mix step ends the tick. Timed-out ticks skip the load and
// divide steps; a window that needs no divide skips its channel's divider.
// Reset is asynchronous and active low; all control and configuration
// registers come up at their reset values (datapath flops and queue storage
// are not reset) and the drive starts timed out. No clearing pass is needed.
// full rises only when the two-entry job queue is full; an unpopped result
// holds the back end before it writes the next result; the front stops at full.
module emg_differential_drive_mixer_core (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // input items
    input  logic                                     push,
    output logic                                     full,
    input  logic [emgdm_pkg::CMD_BITS-1:0]           command,
    input  logic [emgdm_pkg::SAMPLE_BITS-1:0]        emg_ch1,
    input  logic [emgdm_pkg::SAMPLE_BITS-1:0]        emg_ch2,
    input  logic [emgdm_pkg::DIST_BITS-1:0]          range_mm,
    // results
    output logic                                     empty,
    input  logic                                     pop,
    output logic signed [emgdm_pkg::DRIVE_BITS-1:0]  left_drive,
    output logic signed [emgdm_pkg::DRIVE_BITS-1:0]  right_drive,
    // configuration writes
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [emgdm_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [emgdm_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import emgdm_pkg::*;

    logic jobq_full;
    logic jobq_empty;
    logic job_push;
    logic jobq_pop;
    job_t job_in;
    job_t job_out;

    // Registers are plain flops, so a write is always taken at once
    assign cfg_ready = 1'b1;
    assign full      = jobq_full;

    // Classify commands, keep state, build tick jobs
    emgdm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .command   (command),
        .emg_ch1   (emg_ch1),
        .emg_ch2   (emg_ch2),
        .range_mm  (range_mm),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .jobq_full (jobq_full),
        .job_push  (job_push),
        .job       (job_in)
    );

    // Hold pending ticks while the divider is busy
    emgdm_job_queue u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (jobq_pop),
        .rd_data (job_out),
        .full    (jobq_full),
        .empty   (jobq_empty)
    );

    // Divide, mix, gate and present the result
    emgdm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .jobq_empty  (jobq_empty),
        .job         (job_out),
        .jobq_pop    (jobq_pop),
        .pop         (pop),
        .empty       (empty),
        .left_drive  (left_drive),
        .right_drive (right_drive)
    );

endmodule
